[src/rrts_pkg.sv]
package rrts_pkg;

  // Default number of task slots; slot 0 is the idle task.
  localparam int DEF_TASK_SLOTS = 16;

  // Fixed field widths of the item and result channels.
  localparam int ACTION_W   = 3;
  localparam int COUNT_W    = 32;
  localparam int TARGET_W   = 4;
  localparam int OUT_SLOT_W = 4;

  // Action codes carried by in_action.
  localparam logic [ACTION_W-1:0] ACT_TICK        = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_SLEEP       = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_EXIT        = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_SET_ALARM   = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_SET_HANDLER = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_CREATE      = 3'd5;

  // Per-slot task state.
  typedef enum logic [1:0] {
    ST_UNUSED  = 2'd0,
    ST_READY   = 2'd1,
    ST_RUNNING = 2'd2,
    ST_WAITING = 2'd3
  } task_st_t;

  // Commands from the controller to the datapath.
  typedef enum logic [2:0] {
    OP_NONE    = 3'd0,
    OP_LATCH   = 3'd1,
    OP_ALARM   = 3'd2,
    OP_WALK    = 3'd3,
    OP_PICK    = 3'd4,
    OP_SWITCH  = 3'd5,
    OP_EXIT    = 3'd6,
    OP_SYSCALL = 3'd7
  } dp_op_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic alarm_fire;
    logic walk_done;
    logic pick_done;
    logic others_live;
  } dp_status_t;

endpackage

[src/rrts_ctrl.sv]
module rrts_ctrl
  import rrts_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [ACTION_W-1:0] in_action,
  input  dp_status_t          status,
  output dp_op_t              op,
  output logic                busy,
  output logic                out_valid
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ALARM_RD,
    S_ALARM_UPD,
    S_WALK,
    S_PICK,
    S_SWITCH,
    S_EXIT,
    S_SYSCALL,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;

  // The result is shown in the done cycle, which also takes a new item.
  assign busy      = (state_r != S_IDLE) && (state_r != S_DONE);
  assign out_valid = (state_r == S_DONE);

  // Next-state and command decode.
  always_comb begin
    state_nxt = state_r;
    op        = OP_NONE;
    case (state_r)
      S_IDLE, S_DONE: begin
        state_nxt = S_IDLE;
        if (start) begin
          op = OP_LATCH;
          if (in_action == ACT_TICK) begin
            state_nxt = S_ALARM_RD;
          end else if (in_action == ACT_EXIT) begin
            state_nxt = S_EXIT;
          end else begin
            state_nxt = S_SYSCALL;
          end
        end
      end
      S_ALARM_RD: begin
        state_nxt = S_ALARM_UPD;
      end
      S_ALARM_UPD: begin
        op        = OP_ALARM;
        state_nxt = status.alarm_fire ? S_DONE : S_WALK;
      end
      S_WALK: begin
        op = OP_WALK;
        if (status.walk_done) begin
          state_nxt = S_PICK;
        end
      end
      S_PICK: begin
        op = OP_PICK;
        if (status.pick_done) begin
          state_nxt = S_SWITCH;
        end
      end
      S_SWITCH: begin
        op        = OP_SWITCH;
        state_nxt = S_DONE;
      end
      S_EXIT: begin
        op        = OP_EXIT;
        state_nxt = status.others_live ? S_PICK : S_DONE;
      end
      S_SYSCALL: begin
        op        = OP_SYSCALL;
        state_nxt = S_DONE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Every result follows a busy cycle.
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without preceding work");

  // Work never ends without a result.
  a_work_ends_in_result: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> (busy || out_valid))
    else $error("item dropped without a result");

endmodule

[src/rrts_dp.sv]
module rrts_dp
  import rrts_pkg::*;
#(
  parameter int TASK_SLOTS = DEF_TASK_SLOTS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_op_t                op,
  input  logic [ACTION_W-1:0]   in_action,
  input  logic [COUNT_W-1:0]    in_count_value,
  input  logic                  in_handler_present,
  input  logic [TARGET_W-1:0]   in_target_slot,
  output dp_status_t            status,
  output logic [OUT_SLOT_W-1:0] running_slot,
  output logic                  switched,
  output logic                  alarm_signal,
  output logic                  shutdown
);

  localparam int SLOT_W = $clog2(TASK_SLOTS);
  localparam int IDX_W  = SLOT_W + 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TASK_SLOTS - 1);
  localparam logic [IDX_W-1:0]  SLOT_END  = IDX_W'(TASK_SLOTS);

  // Latched item fields.
  logic [ACTION_W-1:0] act_r;
  logic [COUNT_W-1:0]  cnt_r;
  logic                hnd_r;
  logic [TARGET_W-1:0] tgt_r;

  // Control state.
  logic [SLOT_W-1:0] cur_r, cur_nxt;
  logic [SLOT_W-1:0] old_r, old_nxt;
  logic [SLOT_W-1:0] next_r, next_nxt;
  logic [SLOT_W-1:0] pk_r, pk_nxt;
  logic [SLOT_W-1:0] steps_r, steps_nxt;
  logic [IDX_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic [SLOT_W-1:0] wr_idx_r, wr_idx_nxt;
  logic              pend_r, pend_nxt;
  logic              sig_r, sig_nxt;
  logic              shut_r, shut_nxt;
  task_st_t          st_r [TASK_SLOTS];
  task_st_t          st_nxt [TASK_SLOTS];
  logic [TASK_SLOTS-1:0] flag_r, flag_nxt;
  logic [TASK_SLOTS-1:0] sleep_v_r, sleep_v_nxt;
  logic [TASK_SLOTS-1:0] alarm_v_r, alarm_v_nxt;
  logic [TASK_SLOTS-1:0] period_v_r, period_v_nxt;

  // Count memories with registered read data.
  logic [COUNT_W-1:0] sleep_mem  [TASK_SLOTS];
  logic [COUNT_W-1:0] alarm_mem  [TASK_SLOTS];
  logic [COUNT_W-1:0] period_mem [TASK_SLOTS];
  logic [COUNT_W-1:0] sleep_rd_r, alarm_rd_r, period_rd_r;

  logic               sleep_we, alarm_we, period_we;
  logic [SLOT_W-1:0]  sleep_waddr, sleep_raddr;
  logic [COUNT_W-1:0] sleep_wdata, alarm_wdata;

  logic [COUNT_W-1:0] alarm_val, alarm_dec, period_val, sleep_val;
  logic               alarm_fire, walk_done, cand_run, pick_last, pick_done;
  logic               others_live, create_ok;
  logic [SLOT_W-1:0]  tgt_idx, pick_first, fallback;

  // Entries never written read as zero.
  assign alarm_val  = alarm_v_r[cur_r] ? alarm_rd_r : '0;
  assign period_val = period_v_r[cur_r] ? period_rd_r : '0;
  assign sleep_val  = sleep_v_r[wr_idx_r] ? sleep_rd_r : '0;
  assign alarm_dec  = alarm_val - COUNT_W'(1);

  // Alarm expiry with a handler ends the tick early.
  assign alarm_fire = (alarm_val != '0) && (alarm_dec == '0) && flag_r[cur_r];

  // Sleep walk reads one slot per cycle and writes it back in the next cycle.
  assign sleep_raddr = (rd_idx_r == SLOT_END) ? '0 : rd_idx_r[SLOT_W-1:0];
  assign walk_done   = pend_r && (wr_idx_r == LAST_SLOT);

  // Round-robin pick: one candidate slot per cycle after the current one.
  assign pick_first = (cur_r == LAST_SLOT) ? '0 : cur_r + SLOT_W'(1);
  assign cand_run   = (pk_r != '0) &&
                      ((st_r[pk_r] == ST_READY) || (st_r[pk_r] == ST_RUNNING));
  assign pick_last  = (steps_r == LAST_SLOT);
  assign pick_done  = cand_run || pick_last;
  assign fallback   = ((st_r[cur_r] == ST_READY) || (st_r[cur_r] == ST_RUNNING)) ?
                      cur_r : '0;

  // Any live task other than the idle task and the current one.
  always_comb begin
    others_live = 1'b0;
    for (int i = 1; i < TASK_SLOTS; i++) begin
      if ((SLOT_W'(i) != cur_r) && (st_r[i] != ST_UNUSED)) begin
        others_live = 1'b1;
      end
    end
  end

  // Create is honored only for an unused slot in range other than slot 0.
  assign tgt_idx   = SLOT_W'(tgt_r);
  assign create_ok = (tgt_r != '0) && (32'(tgt_r) < 32'(TASK_SLOTS)) &&
                     (st_r[tgt_idx] == ST_UNUSED);

  assign status.alarm_fire  = alarm_fire;
  assign status.walk_done   = walk_done;
  assign status.pick_done   = pick_done;
  assign status.others_live = others_live;

  // Next-state logic for all commands.
  always_comb begin
    cur_nxt      = cur_r;
    old_nxt      = old_r;
    next_nxt     = next_r;
    pk_nxt       = pk_r;
    steps_nxt    = steps_r;
    rd_idx_nxt   = rd_idx_r;
    wr_idx_nxt   = wr_idx_r;
    pend_nxt     = pend_r;
    sig_nxt      = sig_r;
    shut_nxt     = shut_r;
    st_nxt       = st_r;
    flag_nxt     = flag_r;
    sleep_v_nxt  = sleep_v_r;
    alarm_v_nxt  = alarm_v_r;
    period_v_nxt = period_v_r;
    sleep_we     = 1'b0;
    sleep_waddr  = cur_r;
    sleep_wdata  = cnt_r;
    alarm_we     = 1'b0;
    alarm_wdata  = cnt_r;
    period_we    = 1'b0;
    case (op)
      OP_LATCH: begin
        old_nxt  = cur_r;
        sig_nxt  = 1'b0;
        shut_nxt = 1'b0;
      end
      OP_ALARM: begin
        if (alarm_val != '0) begin
          alarm_we = 1'b1;
          if (alarm_fire) begin
            alarm_wdata = period_val;
            sig_nxt     = 1'b1;
          end else begin
            alarm_wdata = alarm_dec;
          end
        end
        rd_idx_nxt = IDX_W'(1);
        pend_nxt   = 1'b0;
      end
      OP_WALK: begin
        if (rd_idx_r != SLOT_END) begin
          pend_nxt   = 1'b1;
          wr_idx_nxt = rd_idx_r[SLOT_W-1:0];
          rd_idx_nxt = rd_idx_r + IDX_W'(1);
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r && (sleep_val != '0)) begin
          sleep_we    = 1'b1;
          sleep_waddr = wr_idx_r;
          sleep_wdata = sleep_val - COUNT_W'(1);
          if (sleep_val == COUNT_W'(1)) begin
            st_nxt[wr_idx_r] = ST_READY;
          end
        end
        if (walk_done) begin
          pk_nxt    = pick_first;
          steps_nxt = SLOT_W'(1);
        end
      end
      OP_PICK: begin
        if (cand_run) begin
          next_nxt = pk_r;
        end else if (pick_last) begin
          next_nxt = fallback;
        end else begin
          pk_nxt    = (pk_r == LAST_SLOT) ? '0 : pk_r + SLOT_W'(1);
          steps_nxt = steps_r + SLOT_W'(1);
        end
      end
      OP_SWITCH: begin
        if (act_r == ACT_TICK) begin
          if (next_r != cur_r) begin
            if (st_r[cur_r] == ST_RUNNING) begin
              st_nxt[cur_r] = ST_READY;
            end
            st_nxt[next_r] = ST_RUNNING;
            cur_nxt        = next_r;
          end
        end else begin
          st_nxt[next_r] = ST_RUNNING;
          cur_nxt        = next_r;
        end
      end
      OP_EXIT: begin
        st_nxt[cur_r] = ST_UNUSED;
        if (others_live) begin
          pk_nxt    = pick_first;
          steps_nxt = SLOT_W'(1);
        end else begin
          shut_nxt = 1'b1;
        end
      end
      OP_SYSCALL: begin
        case (act_r)
          ACT_SLEEP: begin
            sleep_we      = 1'b1;
            st_nxt[cur_r] = (cnt_r != '0) ? ST_WAITING : ST_READY;
            st_nxt[0]     = ST_RUNNING;
            cur_nxt       = '0;
          end
          ACT_SET_ALARM: begin
            alarm_we  = 1'b1;
            period_we = 1'b1;
          end
          ACT_SET_HANDLER: begin
            flag_nxt[cur_r] = hnd_r;
          end
          ACT_CREATE: begin
            if (create_ok) begin
              flag_nxt[tgt_idx]     = flag_r[cur_r];
              st_nxt[tgt_idx]       = ST_READY;
              sleep_v_nxt[tgt_idx]  = 1'b0;
              alarm_v_nxt[tgt_idx]  = 1'b0;
              period_v_nxt[tgt_idx] = 1'b0;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
    // A written entry holds real data until a create reuses its slot.
    if (sleep_we) begin
      sleep_v_nxt[sleep_waddr] = 1'b1;
    end
    if (alarm_we) begin
      alarm_v_nxt[cur_r] = 1'b1;
    end
    if (period_we) begin
      period_v_nxt[cur_r] = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r      <= '0;
      old_r      <= '0;
      pend_r     <= 1'b0;
      sig_r      <= 1'b0;
      shut_r     <= 1'b0;
      flag_r     <= '0;
      sleep_v_r  <= '0;
      alarm_v_r  <= '0;
      period_v_r <= '0;
      for (int i = 0; i < TASK_SLOTS; i++) begin
        st_r[i] <= (i == 0) ? ST_RUNNING : ST_UNUSED;
      end
    end else begin
      cur_r      <= cur_nxt;
      old_r      <= old_nxt;
      pend_r     <= pend_nxt;
      sig_r      <= sig_nxt;
      shut_r     <= shut_nxt;
      flag_r     <= flag_nxt;
      sleep_v_r  <= sleep_v_nxt;
      alarm_v_r  <= alarm_v_nxt;
      period_v_r <= period_v_nxt;
      st_r       <= st_nxt;
    end
  end

  // Payload and scan registers.
  always_ff @(posedge clk) begin
    if (op == OP_LATCH) begin
      act_r <= in_action;
      cnt_r <= in_count_value;
      hnd_r <= in_handler_present;
      tgt_r <= in_target_slot;
    end
    next_r   <= next_nxt;
    pk_r     <= pk_nxt;
    steps_r  <= steps_nxt;
    rd_idx_r <= rd_idx_nxt;
    wr_idx_r <= wr_idx_nxt;
  end

  // Sleep count memory.
  always_ff @(posedge clk) begin
    if (sleep_we) begin
      sleep_mem[sleep_waddr] <= sleep_wdata;
    end
    sleep_rd_r <= sleep_mem[sleep_raddr];
  end

  // Alarm count memory.
  always_ff @(posedge clk) begin
    if (alarm_we) begin
      alarm_mem[cur_r] <= alarm_wdata;
    end
    alarm_rd_r <= alarm_mem[cur_r];
  end

  // Alarm period memory.
  always_ff @(posedge clk) begin
    if (period_we) begin
      period_mem[cur_r] <= cnt_r;
    end
    period_rd_r <= period_mem[cur_r];
  end

  assign running_slot = OUT_SLOT_W'(cur_r);
  assign switched     = (cur_r != old_r);
  assign alarm_signal = sig_r;
  assign shutdown     = shut_r;

  // The idle task's sleep count is never counted down.
  a_walk_skips_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (wr_idx_r != '0))
    else $error("sleep walk touched the idle slot");

  // An alarm tick ends before any exit handling, so both flags never meet.
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(sig_r && shut_r))
    else $error("alarm and shutdown raised together");

  // Sleep always hands the processor to the idle task.
  a_sleep_runs_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ((op == OP_SYSCALL) && (act_r == ACT_SLEEP)) |=>
      ((cur_r == '0) && (st_r[0] == ST_RUNNING)))
    else $error("sleep did not switch to the idle task");

endmodule

[src/round_robin_task_scheduler.sv]
// Round-robin task scheduler over TASK_SLOTS task slots, slot 0 being idle.
// Item channel: an item (in_action, in_count_value, in_handler_present,
// in_target_slot) is taken at a rising edge with start high and busy low.
// Result channel: out_valid is high for exactly one cycle with
// out_running_slot, out_switched, out_alarm_signal and out_shutdown; the
// result is taken at the edge that ends that cycle and cannot be held off.
// A sleep, set alarm, set handler, create or undefined action runs one
// system-call step; a tick reads and updates the current task's alarm and
// ends there if the alarm fires, else goes on to the sleep-count walk,
// which reads and writes back one slot of the sleep memory per cycle, and
// the pick, which checks one slot per cycle, then switches tasks; exit
// frees the current slot and, if other tasks live, picks and switches.
// The result cycle also accepts the next item; no new item is taken
// while one is in work. After reset slot 0 is running, all other slots
// are unused and all counts read as zero; no clearing pass is needed.
module round_robin_task_scheduler
  import rrts_pkg::*;
#(
  parameter int TASK_SLOTS = DEF_TASK_SLOTS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [ACTION_W-1:0]   in_action,
  input  logic [COUNT_W-1:0]    in_count_value,
  input  logic                  in_handler_present,
  input  logic [TARGET_W-1:0]   in_target_slot,
  output logic                  out_valid,
  output logic [OUT_SLOT_W-1:0] out_running_slot,
  output logic                  out_switched,
  output logic                  out_alarm_signal,
  output logic                  out_shutdown
);

  dp_op_t     op;
  dp_status_t status;

  // Sequencer for ticks and system calls.
  rrts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_action (in_action),
    .status    (status),
    .op        (op),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // Task table, count memories and pick logic.
  rrts_dp #(
    .TASK_SLOTS (TASK_SLOTS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .op                 (op),
    .in_action          (in_action),
    .in_count_value     (in_count_value),
    .in_handler_present (in_handler_present),
    .in_target_slot     (in_target_slot),
    .status             (status),
    .running_slot       (out_running_slot),
    .switched           (out_switched),
    .alarm_signal       (out_alarm_signal),
    .shutdown           (out_shutdown)
  );

endmodule
